@@ sv/bbs_pkg.sv @@
// Shared types, register codes and constants of the streaming box blur.
`default_nettype none

package bbs_pkg;

  // Default line capacity in pixels.
  localparam int MAX_WIDTH_DEF = 2048;

  // Byte channels per pixel and the packed pixel width.
  localparam int CHANNELS = 4;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = CHANNELS * CHAN_W;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd3;

  // Register widths and reset values.
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int MODE_REG_W   = 2;
  localparam int CHAN_REG_W   = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST    = 12'd2048;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST   = 16'd2048;
  localparam logic [MODE_REG_W-1:0]   MODE_RST     = 2'd0;
  localparam logic [CHAN_REG_W-1:0]   CHANNELS_RST = 3'd3;

  // Filter modes.
  localparam logic [MODE_REG_W-1:0] MODE_BOX   = 2'd0;
  localparam logic [MODE_REG_W-1:0] MODE_HORIZ = 2'd1;
  localparam logic [MODE_REG_W-1:0] MODE_VERT  = 2'd2;

  // Beat commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Input beat.
  typedef struct packed {
    logic              cmd;
    logic [CHAN_W-1:0] channel_3;
    logic [CHAN_W-1:0] channel_2;
    logic [CHAN_W-1:0] channel_1;
    logic [CHAN_W-1:0] channel_0;
  } pix_beat_t;

  // Result beat.
  typedef struct packed {
    logic              last_pixel;
    logic [CHAN_W-1:0] out_ch3;
    logic [CHAN_W-1:0] out_ch2;
    logic [CHAN_W-1:0] out_ch1;
    logic [CHAN_W-1:0] out_ch0;
  } res_beat_t;

  // Per-result tap qualifiers and edge flags handed to the filter.
  typedef struct packed {
    logic right_ok;
    logic below_ok;
    logic diag_ok;
    logic last_col;
    logic last_row;
  } tap_ctrl_t;

endpackage

`default_nettype wire

@@ sv/box_blur_stream_top.sv @@
// Throughput: one beat per cycle on both channels, sustained while res_ready stays high;
// the line RAM takes one write and two reads per cycle, and two taps come from registers.
// Result path: a beat that releases a pixel is read from the RAM at its accepting edge into
// the read stage, then enters the output register once that is free; the first width+1 pixels fill.
// Reset (rst, synchronous): pointers, fill count, frame position and registers
// return to defaults; the line RAM is not cleared and needs no clearing pass.
`default_nettype none

module box_blur_stream_top #(
  parameter int MAX_WIDTH = bbs_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 pix_valid,
  output logic                                      pix_ready,
  input  wire bbs_pkg::pix_beat_t                   pix,
  output logic                                      res_valid,
  input  wire logic                                 res_ready,
  output bbs_pkg::res_beat_t                        res,
  input  wire logic                                 cfg_write_en,
  input  wire logic [bbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bbs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH + 2);
  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int HW   = bbs_pkg::HEIGHT_REG_W;

  // Configuration registers.
  logic [bbs_pkg::WIDTH_REG_W-1:0] image_width;
  logic [HW-1:0]                   image_height;
  logic [bbs_pkg::MODE_REG_W-1:0]  filter_mode;
  logic [bbs_pkg::CHAN_REG_W-1:0]  channel_count;

  // Ring and frame state.
  logic [AW-1:0]             wr_ptr;
  logic [AW-1:0]             rd_ptr;
  logic [CW-1:0]             fill;
  logic [COLW-1:0]           out_column;
  logic [HW-1:0]             out_row;
  logic [bbs_pkg::PIX_W-1:0] newest;

  // Read stage.
  logic                      s1_valid;
  bbs_pkg::tap_ctrl_t        s1_ctrl;
  logic [bbs_pkg::PIX_W-1:0] s1_px;
  logic [bbs_pkg::PIX_W-1:0] s1_below;
  logic [bbs_pkg::PIX_W-1:0] mem_q_a;
  logic [bbs_pkg::PIX_W-1:0] mem_q_b;

  logic [CW-1:0]             eff_width;
  logic [CW-1:0]             ring_len;
  logic [HW-1:0]             height_m1;
  logic [AW-1:0]             wr_ptr_inc;
  logic [AW-1:0]             rd_ptr_inc;
  logic [bbs_pkg::PIX_W-1:0] px;
  logic                      accept;
  logic                      is_flush;
  logic                      full;
  logic                      empty;
  logic                      do_write;
  logic                      has_result;
  logic                      last_col;
  logic                      last_row;
  logic                      load_ok;
  logic                      s1_move;
  logic                      restart;
  bbs_pkg::tap_ctrl_t        ctrl_next;

  // Effective geometry: width clamped to 1..MAX_WIDTH, height zero acts as one.
  always_comb begin
    if (image_width == '0) begin
      eff_width = CW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = CW'(image_width);
    end
  end

  assign ring_len  = eff_width + CW'(1);
  assign height_m1 = (image_height == '0) ? '0 : image_height - HW'(1);

  // Ring pointer increments wrap at the ring length.
  assign wr_ptr_inc = ((CW'(wr_ptr) + CW'(1)) == ring_len) ? '0 : wr_ptr + AW'(1);
  assign rd_ptr_inc = ((CW'(rd_ptr) + CW'(1)) == ring_len) ? '0 : rd_ptr + AW'(1);

  // Beat decode.
  assign px = {pix.channel_3, pix.channel_2, pix.channel_1, pix.channel_0};
  assign accept     = pix_valid && pix_ready;
  assign is_flush   = (pix.cmd == bbs_pkg::CMD_FLUSH);
  assign full       = (fill == ring_len);
  assign empty      = (fill == '0);
  assign do_write   = accept && !is_flush;
  assign has_result = accept && (is_flush ? !empty : full);

  // Frame position of the pixel being released.
  assign last_col = (CW'(out_column) >= (eff_width - CW'(1)));
  assign last_row = (out_row >= height_m1);

  always_comb begin
    ctrl_next.right_ok = (fill >= CW'(2));
    ctrl_next.below_ok = full;
    ctrl_next.diag_ok  = !is_flush;
    ctrl_next.last_col = last_col;
    ctrl_next.last_row = last_row;
  end

  // Stage handshake.
  assign s1_move   = s1_valid && load_ok;
  assign pix_ready = !s1_valid || s1_move;
  assign restart   = cfg_write_en &&
                     (cfg_index == bbs_pkg::CFG_WIDTH || cfg_index == bbs_pkg::CFG_HEIGHT);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= bbs_pkg::WIDTH_RST;
      image_height  <= bbs_pkg::HEIGHT_RST;
      filter_mode   <= bbs_pkg::MODE_RST;
      channel_count <= bbs_pkg::CHANNELS_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        bbs_pkg::CFG_WIDTH:    image_width   <= cfg_data[bbs_pkg::WIDTH_REG_W-1:0];
        bbs_pkg::CFG_HEIGHT:   image_height  <= cfg_data[HW-1:0];
        bbs_pkg::CFG_MODE:     filter_mode   <= cfg_data[bbs_pkg::MODE_REG_W-1:0];
        bbs_pkg::CFG_CHANNELS: channel_count <= cfg_data[bbs_pkg::CHAN_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Ring pointers, fill count and frame position.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill       <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (do_write && !full) begin
        fill <= fill + CW'(1);
      end else if (accept && is_flush && !empty) begin
        fill <= fill - CW'(1);
      end
      if (has_result) begin
        rd_ptr <= rd_ptr_inc;
        if (last_col) begin
          out_column <= '0;
          out_row    <= last_row ? '0 : out_row + HW'(1);
        end else begin
          out_column <= out_column + COLW'(1);
        end
      end
    end
  end

  // Most recently written pixel, the below tap of a full ring.
  always_ff @(posedge clk) begin
    if (do_write) begin
      newest <= px;
    end
  end

  // Read stage valid and its side data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (has_result) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (has_result) begin
      s1_ctrl  <= ctrl_next;
      s1_px    <= px;
      s1_below <= newest;
    end
  end

  // Oldest pending pixel and its right neighbor come from the RAM.
  bbs_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .wr_en     (do_write),
    .wr_addr   (wr_ptr),
    .wr_data   (px),
    .rd_en     (has_result),
    .rd_addr_a (rd_ptr),
    .rd_addr_b (rd_ptr_inc),
    .rd_data_a (mem_q_a),
    .rd_data_b (mem_q_b)
  );

  bbs_filter u_filter (
    .clk           (clk),
    .rst           (rst),
    .load          (s1_move),
    .load_ok       (load_ok),
    .ctrl          (s1_ctrl),
    .tap_a         (mem_q_a),
    .tap_r         (mem_q_b),
    .tap_b         (s1_below),
    .tap_d         (s1_px),
    .filter_mode   (filter_mode),
    .channel_count (channel_count),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

`ifndef SYNTHESIS
  // The ring never holds more pixels than its length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= ring_len)
    else $error("fill count exceeds ring length");

  // Both pointers stay inside the ring.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (CW'(wr_ptr) < ring_len) && (CW'(rd_ptr) < ring_len))
    else $error("ring pointer outside ring");

  // An empty or full ring has its pointers together.
  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("ring pointers disagree with fill count");

  // A stalled read stage keeps its RAM data.
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> ($stable(mem_q_a) && $stable(mem_q_b)))
    else $error("RAM read data changed under a stall");
`endif

endmodule

`default_nettype wire

@@ sv/bbs_line_mem.sv @@
// Line buffer RAM: one write port and two registered read ports.
`default_nettype none

module bbs_line_mem #(
  parameter int MAX_WIDTH = bbs_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       wr_addr,
  input  wire logic [bbs_pkg::PIX_W-1:0]            wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       rd_addr_a,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       rd_addr_b,
  output logic      [bbs_pkg::PIX_W-1:0]            rd_data_a,
  output logic      [bbs_pkg::PIX_W-1:0]            rd_data_b
);

  localparam int DEPTH = MAX_WIDTH + 1;

  logic [bbs_pkg::PIX_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

@@ sv/bbs_filter.sv @@
// Per-channel averaging of the taps (all four in box mode) and the registered result stage.
`default_nettype none

module bbs_filter (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 load,
  output logic                                      load_ok,
  input  wire bbs_pkg::tap_ctrl_t                   ctrl,
  input  wire logic [bbs_pkg::PIX_W-1:0]            tap_a,
  input  wire logic [bbs_pkg::PIX_W-1:0]            tap_r,
  input  wire logic [bbs_pkg::PIX_W-1:0]            tap_b,
  input  wire logic [bbs_pkg::PIX_W-1:0]            tap_d,
  input  wire logic [bbs_pkg::MODE_REG_W-1:0]       filter_mode,
  input  wire logic [bbs_pkg::CHAN_REG_W-1:0]       channel_count,
  output logic                                      res_valid,
  input  wire logic                                 res_ready,
  output bbs_pkg::res_beat_t                        res
);

  localparam int CW8 = bbs_pkg::CHAN_W;

  logic [bbs_pkg::PIX_W-1:0]      r_px;
  logic [bbs_pkg::PIX_W-1:0]      b_px;
  logic [bbs_pkg::PIX_W-1:0]      d_px;
  logic [bbs_pkg::PIX_W-1:0]      filt_px;
  logic [bbs_pkg::CHAN_REG_W-1:0] used;
  bbs_pkg::res_beat_t             res_next;

  // Missing neighbors read as zero.
  assign r_px = ctrl.right_ok ? tap_r : '0;
  assign b_px = ctrl.below_ok ? tap_b : '0;
  assign d_px = ctrl.diag_ok  ? tap_d : '0;

  // Channel counts above four act as four.
  assign used = (channel_count > bbs_pkg::CHAN_REG_W'(bbs_pkg::CHANNELS)) ?
                bbs_pkg::CHAN_REG_W'(bbs_pkg::CHANNELS) : channel_count;

  // Floor averages per channel; edges of the averaged direction pass the pixel unchanged, unused channels are zero.
  always_comb begin
    logic [CW8-1:0] ca, cr, cb, cd, v;
    logic [CW8+1:0] sum4;
    logic [CW8:0]   sum_h, sum_v;
    filt_px = '0;
    for (int j = 0; j < bbs_pkg::CHANNELS; j++) begin
      ca    = tap_a[CW8*j +: CW8];
      cr    = r_px[CW8*j +: CW8];
      cb    = b_px[CW8*j +: CW8];
      cd    = d_px[CW8*j +: CW8];
      sum4  = (CW8+2)'(ca) + (CW8+2)'(cr) + (CW8+2)'(cb) + (CW8+2)'(cd);
      sum_h = (CW8+1)'(ca) + (CW8+1)'(cr);
      sum_v = (CW8+1)'(ca) + (CW8+1)'(cb);
      v     = ca;
      case (filter_mode)
        bbs_pkg::MODE_BOX: begin
          if (!ctrl.last_col && !ctrl.last_row) v = sum4[CW8+1:2];
        end
        bbs_pkg::MODE_HORIZ: begin
          if (!ctrl.last_col) v = sum_h[CW8:1];
        end
        bbs_pkg::MODE_VERT: begin
          if (!ctrl.last_row) v = sum_v[CW8:1];
        end
        default: begin
          v = ca;
        end
      endcase
      if (bbs_pkg::CHAN_REG_W'(j) < used) begin
        filt_px[CW8*j +: CW8] = v;
      end
    end
  end

  always_comb begin
    res_next.out_ch0    = filt_px[CW8*0 +: CW8];
    res_next.out_ch1    = filt_px[CW8*1 +: CW8];
    res_next.out_ch2    = filt_px[CW8*2 +: CW8];
    res_next.out_ch3    = filt_px[CW8*3 +: CW8];
    res_next.last_pixel = ctrl.last_col && ctrl.last_row;
  end

  // Output register: takes a new beat whenever the old one is gone or leaving.
  assign load_ok = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
